/* sv/qau_pkg.sv */
// ----------------------------------------------------------------------------
// qau_pkg
// Shared widths, opcodes, status codes, token types and saturation helpers
// for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qau_pkg;

  localparam int DW        = 32;                  // component width
  localparam int FRAC_BITS = 16;                  // fraction bits, Q16.16
  localparam int SW        = 2*DW - FRAC_BITS + 3; // exact sum width before sat
  localparam int RW        = 2*DW + 2;            // sum of squares / sqrt width
  localparam int SQ_STEPS  = DW + 1;              // one root bit per stage
  localparam int LW        = DW + 1;              // length width, up to 2^32
  localparam int CW        = LW + FRAC_BITS;      // divider remainder width
  localparam int DIV_STEPS = FRAC_BITS + 1;       // one quotient bit per stage
  localparam int QW        = FRAC_BITS + 1;       // |quotient| <= 1.0

  localparam logic [2:0] FN_MUL   = 3'd0;
  localparam logic [2:0] FN_MULV  = 3'd1;
  localparam logic [2:0] FN_CONJ  = 3'd2;
  localparam logic [2:0] FN_LEN   = 3'd3;
  localparam logic [2:0] FN_NORM  = 3'd4;
  localparam logic [2:0] FN_EQ    = 3'd5;
  localparam logic [2:0] FN_BASIS = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // basis vector index
  localparam logic [1:0] K_FWD   = 2'd0;
  localparam logic [1:0] K_UP    = 2'd1;
  localparam logic [1:0] K_RIGHT = 2'd2;

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [SW-1:0] wide_t;

  localparam word_t MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam word_t MINV = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [2:0]          func;
    logic [1:0]          sub;
    logic [3:0][DW-1:0]  a;
    logic [3:0][DW-1:0]  b;
  } op_t;

  typedef struct packed {
    word_t       x;
    word_t       y;
    word_t       z;
    word_t       w;
    logic        same;
    logic [1:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [2:0]          func;
    res_t                res;
    logic [3:0][DW-1:0]  a;
  } tok_t;

  function automatic logic ovf(wide_t v);
    return (v > wide_t'(MAXV)) || (v < wide_t'(MINV));
  endfunction

  function automatic word_t sat(wide_t v);
    if (v > wide_t'(MAXV)) begin
      return MAXV;
    end else if (v < wide_t'(MINV)) begin
      return MINV;
    end
    return word_t'(v[DW-1:0]);
  endfunction

endpackage

`default_nettype wire

/* sv/qau_if.sv */
// ----------------------------------------------------------------------------
// qau_if
// Valid/ready channels of the quaternion unit: operand beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface qau_in_if;
  import qau_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  word_t       a_x;
  word_t       a_y;
  word_t       a_z;
  word_t       a_w;
  word_t       b_x;
  word_t       b_y;
  word_t       b_z;
  word_t       b_w;

  modport source (output valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  input ready);
  modport sink   (input valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  output ready);
endinterface

interface qau_out_if;
  import qau_pkg::*;
  logic        valid;
  logic        ready;
  word_t       out_x;
  word_t       out_y;
  word_t       out_z;
  word_t       out_w;
  logic        same;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, out_x, out_y, out_z, out_w, same, status, last,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, same, status, last,
                  output ready);
endinterface

`default_nettype wire

/* sv/qau_front.sv */
// ----------------------------------------------------------------------------
// qau_front
// Input stage: registers operand beats, splits a basis request into three
// sub-items (forward, up, right) by holding the input until the right one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  qau_in_if.sink        in_ch,
  output logic          op_vld,
  output qau_pkg::op_t  op
);
  import qau_pkg::*;

  logic [1:0] k_r, k_nxt;
  logic       is_basis;
  logic       take;
  logic       vld_r;
  op_t        op_r;

  assign is_basis    = (in_ch.func == FN_BASIS);
  assign take        = adv && in_ch.valid;
  assign in_ch.ready = adv && (!is_basis || (k_r == K_RIGHT));

  always_comb begin
    k_nxt = k_r;
    if (take && is_basis) begin
      k_nxt = (k_r == K_RIGHT) ? K_FWD : k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= K_FWD;
      vld_r <= 1'b0;
    end else if (adv) begin
      k_r   <= k_nxt;
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r.func <= in_ch.func;
      op_r.sub  <= k_r;
      op_r.a    <= {in_ch.a_w, in_ch.a_z, in_ch.a_y, in_ch.a_x};
      op_r.b    <= {in_ch.b_w, in_ch.b_z, in_ch.b_y, in_ch.b_x};
    end
  end

  assign op_vld = vld_r;
  assign op     = op_r;

endmodule

`default_nettype wire

/* sv/qau_mul.sv */
// ----------------------------------------------------------------------------
// qau_mul
// Product array and combine: 16 registered products, floor shift and
// per-opcode sums, then saturation into a result token.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      op_vld,
  input  qau_pkg::op_t              op,
  output logic                      tok_vld,
  output qau_pkg::tok_t             tok,
  output logic [qau_pkg::RW-1:0]    sq
);
  import qau_pkg::*;

  localparam wide_t ONE = wide_t'(1) << FRAC_BITS;

  // stage 1: products
  logic [3:0][DW-1:0]          bsel;
  logic [3:0][3:0][2*DW-1:0]   p_r;
  op_t                         op1_r;
  logic                        vld1_r;

  // stage 2: exact sums
  wide_t                       f [4][4];
  wide_t                       v_nxt [4];
  wide_t                       v_r [4];
  logic [RW-1:0]               sq_nxt, sq2_r;
  logic                        same_nxt, same2_r;
  logic [2:0]                  func2_r;
  logic [1:0]                  sub2_r;
  logic [3:0][DW-1:0]          a2_r;
  logic                        vld2_r;

  // stage 3: saturated token
  tok_t                        tok_nxt, tok_r;
  logic [RW-1:0]               sq3_r;
  logic                        vld3_r;
  logic                        ov;

  always_comb begin
    bsel = op.b;
    case (op.func) inside
      FN_BASIS, FN_LEN, FN_NORM: bsel = op.a;
      FN_MULV:                   bsel[3] = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p_r[i][j] <= $signed(op.a[i]) * $signed(bsel[j]);
        end
      end
      op1_r <= op;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        f[i][j] = wide_t'($signed(p_r[i][j]) >>> FRAC_BITS);
      end
      v_nxt[i] = '0;
    end
    case (op1_r.func) inside
      FN_MUL, FN_MULV: begin
        v_nxt[0] = f[0][3] + f[3][0] + f[1][2] - f[2][1];
        v_nxt[1] = f[1][3] + f[3][1] + f[2][0] - f[0][2];
        v_nxt[2] = f[2][3] + f[3][2] + f[0][1] - f[1][0];
        v_nxt[3] = f[3][3] - f[0][0] - f[1][1] - f[2][2];
      end
      FN_CONJ: begin
        v_nxt[0] = -wide_t'($signed(op1_r.a[0]));
        v_nxt[1] = -wide_t'($signed(op1_r.a[1]));
        v_nxt[2] = -wide_t'($signed(op1_r.a[2]));
        v_nxt[3] = wide_t'($signed(op1_r.a[3]));
      end
      FN_BASIS: begin
        case (op1_r.sub)
          K_FWD: begin
            v_nxt[0] = (f[0][2] - f[3][1]) <<< 1;
            v_nxt[1] = (f[1][2] + f[3][0]) <<< 1;
            v_nxt[2] = ONE - ((f[0][0] + f[1][1]) <<< 1);
          end
          K_UP: begin
            v_nxt[0] = (f[0][1] + f[3][2]) <<< 1;
            v_nxt[1] = ONE - ((f[0][0] + f[2][2]) <<< 1);
            v_nxt[2] = (f[1][2] - f[3][0]) <<< 1;
          end
          default: begin
            v_nxt[0] = ONE - ((f[1][1] + f[2][2]) <<< 1);
            v_nxt[1] = (f[0][1] - f[3][2]) <<< 1;
            v_nxt[2] = (f[0][2] + f[3][1]) <<< 1;
          end
        endcase
      end
      default: ;
    endcase
    sq_nxt   = RW'(p_r[0][0]) + RW'(p_r[1][1]) + RW'(p_r[2][2]) + RW'(p_r[3][3]);
    same_nxt = (op1_r.func == FN_EQ) && (op1_r.a == op1_r.b);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r     <= v_nxt;
      sq2_r   <= sq_nxt;
      same2_r <= same_nxt;
      func2_r <= op1_r.func;
      sub2_r  <= op1_r.sub;
      a2_r    <= op1_r.a;
    end
  end

  always_comb begin
    ov                 = ovf(v_r[0]) || ovf(v_r[1]) || ovf(v_r[2]) || ovf(v_r[3]);
    tok_nxt.func       = func2_r;
    tok_nxt.a          = a2_r;
    tok_nxt.res.x      = sat(v_r[0]);
    tok_nxt.res.y      = sat(v_r[1]);
    tok_nxt.res.z      = sat(v_r[2]);
    tok_nxt.res.w      = sat(v_r[3]);
    tok_nxt.res.same   = same2_r;
    tok_nxt.res.status = ov ? ST_SAT : ST_OK;
    tok_nxt.res.last   = (func2_r != FN_BASIS) || (sub2_r == K_RIGHT);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
      sq3_r <= sq2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= op_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  assign tok_vld = vld3_r;
  assign tok     = tok_r;
  assign sq      = sq3_r;

endmodule

`default_nettype wire

/* sv/qau_sqrt.sv */
// ----------------------------------------------------------------------------
// qau_sqrt
// Pipelined integer square root of the sum of squares, one root bit per
// stage, result tokens riding along.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  qau_pkg::tok_t            in_tok,
  input  logic [qau_pkg::RW-1:0]   in_sq,
  output logic                     out_vld,
  output qau_pkg::tok_t            out_tok,
  output logic [qau_pkg::LW-1:0]   out_len
);
  import qau_pkg::*;

  logic          sv [SQ_STEPS];
  tok_t          st [SQ_STEPS];
  logic [RW-1:0] sn [SQ_STEPS];
  logic [RW-1:0] sr [SQ_STEPS];

  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
    localparam int BP = 2*(SQ_STEPS-1-s);

    logic          v_in, v_r;
    tok_t          t_in, t_r;
    logic [RW-1:0] n_in, r_in, trial, n_r, r_r;

    if (s == 0) begin : g_first
      assign v_in = in_vld;
      assign t_in = in_tok;
      assign n_in = in_sq;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = sv[s-1];
      assign t_in = st[s-1];
      assign n_in = sn[s-1];
      assign r_in = sr[s-1];
    end

    assign trial = r_in + (RW'(1) << BP);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        t_r <= t_in;
        if (n_in >= trial) begin
          n_r <= n_in - trial;
          r_r <= (r_in >> 1) + (RW'(1) << BP);
        end else begin
          n_r <= n_in;
          r_r <= r_in >> 1;
        end
      end
    end

    assign sv[s] = v_r;
    assign st[s] = t_r;
    assign sn[s] = n_r;
    assign sr[s] = r_r;
  end

  assign out_vld = sv[SQ_STEPS-1];
  assign out_tok = st[SQ_STEPS-1];
  assign out_len = sr[SQ_STEPS-1][LW-1:0];

endmodule

`default_nettype wire

/* sv/qau_div.sv */
// ----------------------------------------------------------------------------
// qau_div
// Length result and normalize: entry stage, then a four-lane restoring
// divider, one quotient bit per stage; final sign fix-up.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  qau_pkg::tok_t            in_tok,
  input  logic [qau_pkg::LW-1:0]   in_len,
  output logic                     out_vld,
  output qau_pkg::res_t            out_res
);
  import qau_pkg::*;

  typedef struct packed {
    tok_t                tok;
    logic [LW-1:0]       len;
    logic                do_div;
    logic [3:0]          neg;
    logic [3:0][CW-1:0]  rem;
    logic [3:0][QW-1:0]  q;
  } dst_t;

  dst_t          ent_nxt, ent_r;
  logic          ent_v_r;
  logic [DW-1:0] mag [4];
  dst_t          st [DIV_STEPS+1];
  logic          sv [DIV_STEPS+1];
  dst_t          fin;
  word_t         qs [4];

  always_comb begin
    ent_nxt     = '0;
    ent_nxt.tok = in_tok;
    ent_nxt.len = in_len;
    for (int i = 0; i < 4; i++) begin
      ent_nxt.neg[i] = in_tok.a[i][DW-1];
      mag[i]         = ent_nxt.neg[i] ? (~in_tok.a[i] + 1'b1) : in_tok.a[i];
      ent_nxt.rem[i] = CW'(mag[i]) << FRAC_BITS;
    end
    case (in_tok.func)
      FN_LEN: begin
        if (in_len > LW'(MAXV)) begin
          ent_nxt.tok.res.w      = MAXV;
          ent_nxt.tok.res.status = ST_SAT;
        end else begin
          ent_nxt.tok.res.w = word_t'(in_len[DW-1:0]);
        end
      end
      FN_NORM: begin
        if (in_len == '0) begin
          ent_nxt.tok.res.status = ST_ZERO;
        end else begin
          ent_nxt.do_div = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r <= 1'b0;
    end else if (adv) begin
      ent_v_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_r <= ent_nxt;
    end
  end

  assign st[0] = ent_r;
  assign sv[0] = ent_v_r;

  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
    localparam int BI = FRAC_BITS + 1 - s;

    dst_t          d_nxt, d_r;
    logic          v_r;
    logic [CW-1:0] dv;

    assign dv = CW'(st[s-1].len) << BI;

    always_comb begin
      d_nxt = st[s-1];
      for (int i = 0; i < 4; i++) begin
        if (st[s-1].rem[i] >= dv) begin
          d_nxt.rem[i]   = st[s-1].rem[i] - dv;
          d_nxt.q[i][BI] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= sv[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_r <= d_nxt;
      end
    end

    assign st[s] = d_r;
    assign sv[s] = v_r;
  end

  // quotient truncates toward zero: negate the magnitude for negative inputs
  always_comb begin
    fin     = st[DIV_STEPS];
    out_res = fin.tok.res;
    for (int i = 0; i < 4; i++) begin
      qs[i] = fin.neg[i] ? -word_t'(fin.q[i]) : word_t'(fin.q[i]);
    end
    if (fin.do_div) begin
      out_res.x = qs[0];
      out_res.y = qs[1];
      out_res.z = qs[2];
      out_res.w = qs[3];
    end
  end

  assign out_vld = sv[DIV_STEPS];

endmodule

`default_nettype wire

/* sv/quaternion_arith_unit_top.sv */
// ----------------------------------------------------------------------------
// quaternion_arith_unit_top
// Fixed-point Q16.16 quaternion unit: product, vector product, conjugate,
// length, normalize, equality and rotation basis.
// ----------------------------------------------------------------------------
// Pipeline: input register, products, sums, saturation, a 33-stage square root,
//   divider entry, FRAC_BITS+1 Q16.16 divider steps and the output register.
// Throughput: one beat per cycle in and out unless the output stalls; a basis
//   request holds the input for three sub-items and yields three result beats.
// Reset: rst_n synchronous, active low; clears valid bits, the output valid
//   and the basis counter. Data registers, output data included, are not reset.
`default_nettype none

module quaternion_arith_unit_top (
  input  logic       clk,
  input  logic       rst_n,
  qau_in_if.sink     in_ch,
  qau_out_if.source  out_ch
);
  import qau_pkg::*;

  // pipeline links
  logic           op_vld;
  op_t            op;
  logic           m_vld;
  tok_t           m_tok;
  logic [RW-1:0]  m_sq;
  logic           q_vld;
  tok_t           q_tok;
  logic [LW-1:0]  q_len;
  logic           d_vld;
  res_t           d_res;

  // output register; the pipe keeps moving while its last stage is empty,
  // so a parked result blocks new input beats only once the last stage is full
  logic           out_valid_r;
  res_t           res_r;
  logic           slot_free;
  logic           adv;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign adv       = !d_vld || slot_free;

  // stage 0: input register and basis sequencing
  qau_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_ch  (in_ch),
    .op_vld (op_vld),
    .op     (op)
  );

  // stages 1..3: products, sums, saturation
  qau_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .op_vld  (op_vld),
    .op      (op),
    .tok_vld (m_vld),
    .tok     (m_tok),
    .sq      (m_sq)
  );

  // length: one root bit per stage
  qau_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (m_vld),
    .in_tok  (m_tok),
    .in_sq   (m_sq),
    .out_vld (q_vld),
    .out_tok (q_tok),
    .out_len (q_len)
  );

  // length result, zero-length check, normalize divider
  qau_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (q_vld),
    .in_tok  (q_tok),
    .in_len  (q_len),
    .out_vld (d_vld),
    .out_res (d_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && d_vld) begin
      res_r <= d_res;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.out_x  = res_r.x;
  assign out_ch.out_y  = res_r.y;
  assign out_ch.out_z  = res_r.z;
  assign out_ch.out_w  = res_r.w;
  assign out_ch.same   = res_r.same;
  assign out_ch.status = res_r.status;
  assign out_ch.last   = res_r.last;

endmodule

`default_nettype wire

/* sv/qau_checker.sv */
// ----------------------------------------------------------------------------
// qau_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            out_valid,
  input  logic            out_ready,
  input  qau_pkg::word_t  out_x,
  input  qau_pkg::word_t  out_y,
  input  qau_pkg::word_t  out_z,
  input  qau_pkg::word_t  out_w,
  input  logic            same,
  input  logic [1:0]      status,
  input  logic            last
);
  import qau_pkg::*;

  // nothing comes out the cycle after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(out_w) && $stable(status) && $stable(last))
    else $error("stalled result beat changed");

  // equality beat carries zero components and ends its item
  a_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && same |-> out_x == 0 && out_y == 0 && out_z == 0 && out_w == 0
      && status == ST_OK && last)
    else $error("equality beat malformed");

  // zero-length normalize gives zeros in a single beat
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_ZERO |-> out_x == 0 && out_y == 0 && out_z == 0
      && out_w == 0 && !same && last)
    else $error("zero-length beat malformed");

endmodule

bind quaternion_arith_unit_top qau_checker u_qau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.out_x),
  .out_y     (out_ch.out_y),
  .out_z     (out_ch.out_z),
  .out_w     (out_ch.out_w),
  .same      (out_ch.same),
  .status    (out_ch.status),
  .last      (out_ch.last)
);

`default_nettype wire
